### rtl/rdq_pkg.sv
package rdq_pkg;

  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_W      = $clog2(CAPACITY);
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);

  localparam logic [2:0] ACT_PUSH_BACK  = 3'd0;
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd1;
  localparam logic [2:0] ACT_POP_BACK   = 3'd2;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd3;
  localparam logic [2:0] ACT_CLEAR      = 3'd4;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] item_value;
  } in_word_t;

  typedef struct packed {
    logic [31:0] popped_value;
    logic        empty_error;
    logic        overwrote;
    logic [4:0]  fill_count;
    logic        is_empty_flag;
    logic        is_full_flag;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic push;
    logic at_front;
    logic pop;
    logic at_back;
    logic clear;
    logic err;
    logic over;
  } rdq_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } rdq_stat_t;

endpackage

### rtl/rdq_ctrl.sv
module rdq_ctrl
  import rdq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic [2:0] action_i,
  input  logic      out_stall_i,
  input  rdq_stat_t stat_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  output rdq_cmd_t  cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_HOLD = 1'b1;

  logic st_q, st_d;
  logic load;

  assign in_stall_o  = (st_q == ST_HOLD) && out_stall_i;
  assign load        = in_valid_i && !in_stall_o;
  assign out_valid_o = (st_q == ST_HOLD);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (load) st_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (!load && !out_stall_i) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.load = load;
    unique case (action_i)
      ACT_PUSH_BACK: begin
        cmd_o.push = load;
        cmd_o.over = stat_i.full;
      end
      ACT_PUSH_FRONT: begin
        cmd_o.push     = load;
        cmd_o.at_front = 1'b1;
        cmd_o.over     = stat_i.full;
      end
      ACT_POP_BACK: begin
        cmd_o.pop     = load && !stat_i.empty;
        cmd_o.at_back = 1'b1;
        cmd_o.err     = stat_i.empty;
      end
      ACT_POP_FRONT: begin
        cmd_o.pop = load && !stat_i.empty;
        cmd_o.err = stat_i.empty;
      end
      ACT_CLEAR: begin
        cmd_o.clear = load;
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/rdq_datapath.sv
module rdq_datapath
  import rdq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rdq_cmd_t    cmd_i,
  input  logic [31:0] item_value_i,
  output rdq_stat_t   stat_o,
  output out_word_t   out_word_o
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  logic [DATA_WIDTH-1:0] mem_q [CAPACITY];
  logic [IDX_W-1:0] front_q, front_d, back_q, back_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] front_nx, front_pv, back_nx, back_pv;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] rd_q;
  logic err_q, over_q;
  logic [CNT_W-1:0] cnt_out_q;

  assign front_nx = (front_q == LAST_IDX) ? '0 : front_q + 1'b1;
  assign front_pv = (front_q == '0) ? LAST_IDX : front_q - 1'b1;
  assign back_nx  = (back_q == LAST_IDX) ? '0 : back_q + 1'b1;
  assign back_pv  = (back_q == '0) ? LAST_IDX : back_q - 1'b1;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == FULL_CNT);

  assign wr_addr = cmd_i.at_front ? front_pv : back_q;
  assign rd_addr = cmd_i.at_back ? back_pv : front_q;

  always_comb begin
    front_d = front_q;
    back_d  = back_q;
    count_d = count_q;
    if (cmd_i.clear) begin
      front_d = '0;
      back_d  = '0;
      count_d = '0;
    end else if (cmd_i.push) begin
      if (cmd_i.at_front) begin
        front_d = front_pv;
        if (stat_o.full) back_d = back_pv;
      end else begin
        back_d = back_nx;
        if (stat_o.full) front_d = front_nx;
      end
      if (!stat_o.full) count_d = count_q + 1'b1;
    end else if (cmd_i.pop) begin
      if (cmd_i.at_back) back_d = back_pv;
      else front_d = front_nx;
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= '0;
      count_q <= '0;
    end else begin
      front_q <= front_d;
      back_q  <= back_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[wr_addr] <= item_value_i[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rd_q      <= cmd_i.pop ? mem_q[rd_addr] : '0;
      err_q     <= cmd_i.err;
      over_q    <= cmd_i.over;
      cnt_out_q <= count_d;
    end
  end

  assign out_word_o.popped_value  = 32'(rd_q);
  assign out_word_o.empty_error   = err_q;
  assign out_word_o.overwrote     = over_q;
  assign out_word_o.fill_count    = 5'(cnt_out_q);
  assign out_word_o.is_empty_flag = (cnt_out_q == '0);
  assign out_word_o.is_full_flag  = (cnt_out_q == FULL_CNT);

endmodule

### rtl/ring_deque_overwrite_top.sv
// Double-ended ring buffer of 16 words of 32 bits. Each input word carries one action:
// push back, push front, pop back, pop front or clear, and yields exactly one output word
// with the popped data (zero unless a pop succeeded), the error and overwrite flags, and the
// fill count with its empty and full flags after the action. A push onto a full buffer drops
// the element at the opposite end; a pop on an empty buffer changes nothing. Each action
// completes at its accepting edge: the pointers, the count and the register-file write or read
// all settle there, and the result is held in the output register until taken, so a new word
// is accepted every cycle that the output side does not stall.
module ring_deque_overwrite_top
  import rdq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  rdq_cmd_t  cmd;
  rdq_stat_t stat;

  rdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .action_i    (in_word_i.action),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  rdq_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .item_value_i (in_word_i.item_value),
    .stat_o       (stat),
    .out_word_o   (out_word_o)
  );

endmodule
